>>> src/objdv_pkg.sv
package objdv_pkg;

  localparam int TOKEN_CAPACITY_DEF = 16;
  localparam int DIR_COUNT          = 12;
  localparam int DIR_LEN_MAX        = 6;
  localparam int DIR_LEN_W          = 3;
  localparam int LINE_W             = 32;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef enum logic [1:0] {
    VERDICT_SCANNING = 2'd0,
    VERDICT_ACCEPTED = 2'd1,
    VERDICT_REJECTED = 2'd2
  } verdict_t;

  typedef logic [7:0] tok_byte_t;

  // Directive spellings, padded with zeros past their length
  localparam logic [7:0] DIR_TEXT [DIR_COUNT][DIR_LEN_MAX] = '{
    '{8'h76, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // v
    '{8'h76, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00},  // vt
    '{8'h76, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00},  // vn
    '{8'h76, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},  // vp
    '{8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // f
    '{8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // o
    '{8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // g
    '{8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // s
    '{8'h6D, 8'h74, 8'h6C, 8'h6C, 8'h69, 8'h62},  // mtllib
    '{8'h75, 8'h73, 8'h65, 8'h6D, 8'h74, 8'h6C},  // usemtl
    '{8'h6C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // l
    '{8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}   // p
  };

  localparam logic [DIR_LEN_W-1:0] DIR_LEN [DIR_COUNT] = '{
    3'd1, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd6, 3'd6, 3'd1, 3'd1
  };

endpackage

>>> src/obj_directive_validator_core.sv
// An accepted item moves from the input register into the result register, which drives out_*;
// it waits in the input register while the result register is still held.
// Throughput: one item per cycle; the input register and result register each hold
// one item, so input stalls only when the result register is full and not taken.
// Reset (rst_n low, synchronous) empties both registers and sets line 1, empty token,
// no rejection. An end-of-file item returns the scan state to that same reset state.
module obj_directive_validator_core #(
  parameter int TOKEN_CAPACITY = objdv_pkg::TOKEN_CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // end_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [1:0] verdict, [33:2] error_line, [39:34] zero
);
  import objdv_pkg::*;

  localparam int CNT_W = $clog2(TOKEN_CAPACITY + 1);
  localparam int IDX_W = $clog2(DIR_LEN_MAX);

  // input register
  logic       s_vld_r;
  logic [7:0] s_byte_r;
  logic       s_eof_r;

  // scan state
  tok_byte_t          tok_r [DIR_LEN_MAX];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               rest_r, rest_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic               rej_r, rej_nxt;
  logic               tok_wr;

  // result register
  logic              o_vld_r;
  verdict_t          o_verdict_r, verdict_nxt;
  logic [LINE_W-1:0] o_line_r;

  logic                 adv;
  logic [DIR_LEN_W-1:0] tok_len;
  logic                 tok_pass;
  logic                 is_eol, is_ws;

  assign adv       = s_vld_r & (~o_vld_r | out_tready);
  assign in_tready = ~s_vld_r | adv;

  assign tok_len = (cnt_r <= CNT_W'(DIR_LEN_MAX)) ? cnt_r[DIR_LEN_W-1:0] : '1;

  objdv_match u_match (
    .tok      (tok_r),
    .tok_len  (tok_len),
    .tok_pass (tok_pass)
  );

  assign is_eol = (s_byte_r == CH_LF) | (s_byte_r == CH_CR);
  assign is_ws  = (s_byte_r == CH_SPACE) | (s_byte_r == CH_TAB);

  always_comb begin
    cnt_nxt     = cnt_r;
    rest_nxt    = rest_r;
    line_nxt    = line_r;
    rej_nxt     = rej_r;
    tok_wr      = 1'b0;
    verdict_nxt = VERDICT_SCANNING;
    if (s_eof_r) begin
      verdict_nxt = (rej_r | ~tok_pass) ? VERDICT_REJECTED : VERDICT_ACCEPTED;
      cnt_nxt     = '0;
      rest_nxt    = 1'b0;
      line_nxt    = LINE_W'(1);
      rej_nxt     = 1'b0;
    end else if (!rej_r) begin
      if (is_eol) begin
        if (!tok_pass) begin
          rej_nxt = 1'b1;
        end else begin
          cnt_nxt  = '0;
          rest_nxt = 1'b0;
          if ((s_byte_r == CH_LF) && (line_r != '1)) begin
            line_nxt = line_r + LINE_W'(1);
          end
        end
      end else if (!rest_r) begin
        if ((s_byte_r == CH_HASH) && (cnt_r == '0)) begin
          rest_nxt = 1'b1;
        end else if (is_ws) begin
          if (!tok_pass) begin
            rej_nxt = 1'b1;
          end else if (cnt_r != '0) begin
            rest_nxt = 1'b1;
          end
        end else if (cnt_r >= CNT_W'(TOKEN_CAPACITY)) begin
          rej_nxt = 1'b1;
        end else begin
          // bytes past the longest directive only need counting
          tok_wr  = (cnt_r < CNT_W'(DIR_LEN_MAX));
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      if (rej_nxt) begin
        verdict_nxt = VERDICT_REJECTED;
      end
    end else begin
      verdict_nxt = VERDICT_REJECTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_tready) begin
      s_vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s_byte_r <= in_tdata;
      s_eof_r  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rest_r <= 1'b0;
      line_r <= LINE_W'(1);
      rej_r  <= 1'b0;
    end else if (adv) begin
      cnt_r  <= cnt_nxt;
      rest_r <= rest_nxt;
      line_r <= line_nxt;
      rej_r  <= rej_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok_wr) begin
      tok_r[cnt_r[IDX_W-1:0]] <= s_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= 1'b1;
    end else if (out_tready) begin
      o_vld_r <= 1'b0;
    end
    if (adv) begin
      o_verdict_r <= verdict_nxt;
      // end of file reports the line reached, before the state returns to line 1
      o_line_r    <= s_eof_r ? line_r : line_nxt;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {6'd0, o_line_r, o_verdict_r};

endmodule

>>> src/objdv_match.sv
module objdv_match (
  input  objdv_pkg::tok_byte_t          tok [objdv_pkg::DIR_LEN_MAX],
  input  logic [objdv_pkg::DIR_LEN_W-1:0] tok_len,  // 7: longer than any directive
  output logic                          tok_pass
);
  import objdv_pkg::*;

  always_comb begin
    logic hit;
    logic same;
    hit = 1'b0;
    for (int d = 0; d < DIR_COUNT; d++) begin
      same = (tok_len == DIR_LEN[d]);
      for (int k = 0; k < DIR_LEN_MAX; k++) begin
        if ((DIR_LEN_W'(k) < DIR_LEN[d]) && (tok[k] != DIR_TEXT[d][k])) begin
          same = 1'b0;
        end
      end
      hit = hit | same;
    end
    tok_pass = (tok_len == '0) | hit;
  end

endmodule
